@@ src/itrd_pkg.sv @@
// ----------------------------------------------------------------------------
// itrd_pkg
// Shared types, constants and helpers for the integer to radix digit converter.
// ----------------------------------------------------------------------------
package itrd_pkg;

    // Default width of the converted value
    localparam int VALUE_BITS_DEF = 31;

    // Radix register and digit widths
    localparam int RADIX_BITS = 6;
    localparam int DIGIT_BITS = 6;
    localparam int CHAR_BITS  = 7;

    // Quotient bits resolved by the divider in one cycle
    localparam int DIV_STEP_BITS = 8;

    // Radix limits and reset value
    localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_BITS-1:0] RADIX_RESET = 6'd10;

    // ASCII mapping constants
    localparam logic [DIGIT_BITS-1:0] DIGIT_NINE  = 6'd9;
    localparam logic [CHAR_BITS-1:0]  ASCII_ZERO  = 7'd48;  // '0'
    localparam logic [CHAR_BITS-1:0]  ASCII_ALPHA = 7'd55;  // 'A' - 10

    // Divider status toward the sequencer
    typedef struct packed {
        logic                  done;
        logic [DIGIT_BITS-1:0] rem;
    } div_status_t;

    // Clamp the programmed radix into 2..36
    function automatic logic [RADIX_BITS-1:0] clamp_radix(input logic [RADIX_BITS-1:0] r);
        logic [RADIX_BITS-1:0] c;
        begin
            c = r;
            if (r < RADIX_MIN)
            begin
                c = RADIX_MIN;
            end
            else if (r > RADIX_MAX)
            begin
                c = RADIX_MAX;
            end
            return c;
        end
    endfunction

    // Digit value to ASCII: 0-9 -> '0'-'9', 10-35 -> 'A'-'Z'
    function automatic logic [CHAR_BITS-1:0] digit_to_ascii(input logic [DIGIT_BITS-1:0] d);
        logic [CHAR_BITS-1:0] c;
        begin
            if (d <= DIGIT_NINE)
            begin
                c = {1'b0, d} + ASCII_ZERO;
            end
            else
            begin
                c = {1'b0, d} + ASCII_ALPHA;
            end
            return c;
        end
    endfunction

endpackage

@@ src/integer_to_radix_digits_core.sv @@
// ----------------------------------------------------------------------------
// integer_to_radix_digits_core
// Converts a non-negative integer into ASCII digits of a programmable radix,
// most significant digit first, one output beat per digit.
// ----------------------------------------------------------------------------
//  Channel  | Signals                          | Content
//  ---------+----------------------------------+---------------------------------
//  input    | s_tvalid s_tready s_tdata        | value (zero padded to bytes)
//  output   | m_tvalid m_tready m_tdata m_tuser| digit_char, has_digit, last
//           | m_tlast                          |
//  config   | cfg_we cfg_wdata                 | radix (2..36, clamped)
//
//  Each digit comes from one pass of the single divider and is stored in
//  the digit RAM; once the quotient is zero the digits are emitted by RAM
//  read, load and beat. A new value is taken only once the last is out.
//  Zero input gives a single beat with has_digit low and tlast high.
//  s_tready is high only while idle; a stalled m_tready holds the sequencer.
//  Reset returns to idle with radix 10; the digit RAM needs no clearing.
// ----------------------------------------------------------------------------
module integer_to_radix_digits_core #(
    parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // slave stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0] s_tdata,   // [VALUE_BITS-1:0] value
    // master stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // [6:0] digit_char
    output logic                            m_tuser,   // [0] has_digit
    output logic                            m_tlast,
    // configuration
    input  logic                            cfg_we,
    input  logic [itrd_pkg::RADIX_BITS-1:0] cfg_wdata
);

    localparam int IDX_BITS = $clog2(VALUE_BITS);
    localparam int DB       = itrd_pkg::DIGIT_BITS;
    localparam int CB       = itrd_pkg::CHAR_BITS;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_RD   = 5'b00100,
        ST_LOAD = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t                        state_reg;
    logic [itrd_pkg::RADIX_BITS-1:0] radix_reg;
    logic [itrd_pkg::RADIX_BITS-1:0] radix_eff;
    logic [IDX_BITS-1:0]           idx_reg;
    logic                          out_valid_reg;
    logic [CB-1:0]                 out_char_reg;
    logic                          out_has_reg;
    logic                          out_last_reg;

    logic                          in_beat;
    logic                          out_beat;
    logic                          div_start;
    logic [VALUE_BITS-1:0]         div_dividend;
    logic [VALUE_BITS-1:0]         div_quot;
    itrd_pkg::div_status_t         div_stat;
    logic [DB-1:0]                 ram_rdata;
    logic                          more_digits;

    assign in_beat   = s_tvalid && s_tready;
    assign out_beat  = m_tvalid && m_tready;
    assign radix_eff = itrd_pkg::clamp_radix(radix_reg);

    // Divider start: new nonzero item or next quotient
    assign more_digits  = (state_reg == ST_DIV) && div_stat.done && (div_quot != '0);
    assign div_start    = (in_beat && (s_tdata[VALUE_BITS-1:0] != '0)) || more_digits;
    assign div_dividend = in_beat ? s_tdata[VALUE_BITS-1:0] : div_quot;

    itrd_div #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (radix_eff),
        .quotient (div_quot),
        .status   (div_stat)
    );

    // Digit store, least significant digit at index zero
    itrd_ram #(
        .WIDTH (DB),
        .DEPTH (VALUE_BITS)
    ) u_store (
        .clk   (clk),
        .we    ((state_reg == ST_DIV) && div_stat.done),
        .waddr (idx_reg),
        .wdata (div_stat.rem),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // Radix register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= itrd_pkg::RADIX_RESET;
        end
        else if (cfg_we)
        begin
            radix_reg <= cfg_wdata;
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    idx_reg <= '0;
                    if (in_beat)
                    begin
                        if (s_tdata[VALUE_BITS-1:0] == '0)
                        begin
                            out_valid_reg <= 1'b1;
                            state_reg     <= ST_OUT;
                        end
                        else
                        begin
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV:
                begin
                    if (div_stat.done)
                    begin
                        if (div_quot == '0)
                        begin
                            state_reg <= ST_RD;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + IDX_BITS'(1);
                        end
                    end
                end
                ST_RD:
                begin
                    state_reg <= ST_LOAD;
                end
                ST_LOAD:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_beat)
                    begin
                        out_valid_reg <= 1'b0;
                        if (out_last_reg)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg - IDX_BITS'(1);
                            state_reg <= ST_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            out_char_reg <= '0;
            out_has_reg  <= 1'b0;
            out_last_reg <= 1'b1;
        end
        else if (state_reg == ST_LOAD)
        begin
            out_char_reg <= itrd_pkg::digit_to_ascii(ram_rdata);
            out_has_reg  <= 1'b1;
            out_last_reg <= (idx_reg == '0);
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_char_reg};
    assign m_tuser  = out_has_reg;
    assign m_tlast  = out_last_reg;

    // Checks
    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid)
        else $error("input ready while a beat is pending");

    a_valid_state: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (state_reg == ST_OUT))
        else $error("output valid outside emit state");

    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> m_tlast)
        else $error("empty result not marked last");

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && div_stat.done) |-> (div_stat.rem < radix_eff))
        else $error("remainder not below radix");

endmodule

@@ src/itrd_ram.sv @@
// ----------------------------------------------------------------------------
// itrd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module itrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/itrd_div.sv @@
// ----------------------------------------------------------------------------
// itrd_div
// Iterative restoring divider: value by radix, several quotient bits a cycle.
// ----------------------------------------------------------------------------
module itrd_div #(
    parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [VALUE_BITS-1:0]             dividend,
    input  logic [itrd_pkg::RADIX_BITS-1:0]   divisor,
    output logic [VALUE_BITS-1:0]             quotient,
    output itrd_pkg::div_status_t             status
);

    localparam int STEP     = itrd_pkg::DIV_STEP_BITS;
    localparam int NCYC     = (VALUE_BITS + STEP - 1) / STEP;
    localparam int PAD_BITS = NCYC * STEP;
    localparam int CNT_BITS = $clog2(NCYC + 1);
    localparam int DB       = itrd_pkg::DIGIT_BITS;

    logic [PAD_BITS-1:0] work_reg,  work_next;
    logic [DB-1:0]       rem_reg,   rem_next;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    // STEP dependent compare-subtract steps on the narrow remainder
    always_comb
    begin
        logic [DB:0] t;
        work_next = work_reg;
        rem_next  = rem_reg;
        for (int i = 0; i < STEP; i++)
        begin
            t         = {rem_next, work_next[PAD_BITS-1]};
            work_next = {work_next[PAD_BITS-2:0], 1'b0};
            if (t >= {1'b0, divisor})
            begin
                rem_next     = DB'(t - {1'b0, divisor});
                work_next[0] = 1'b1;
            end
            else
            begin
                rem_next = t[DB-1:0];
            end
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(NCYC);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= PAD_BITS'(dividend);
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    assign quotient    = work_reg[VALUE_BITS-1:0];
    assign status.done = done_reg;
    assign status.rem  = rem_reg;

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the integer to radix digit converter. A directed
// table runs the default radix, the radix extremes, clamping of out-of-range
// radix settings, zero input and masking of the padding bit. Random phases
// then program new radix values and stream mixed values with bursty input
// and a varying output stall pattern. Every output beat is checked against
// a local digit predictor, or against the typed result of a directed row.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int VB         = 31;
    localparam int TDATA_BITS = ((VB + 7) / 8) * 8;
    localparam int PHASES     = 8;
    localparam int PHASE_LEN  = 30;
    localparam int TAIL_CYC   = 300;

    localparam int CHAR_BITS  = itrd_pkg::CHAR_BITS;
    localparam int RADIX_BITS = itrd_pkg::RADIX_BITS;
    localparam int DIGIT_BITS = itrd_pkg::DIGIT_BITS;
    localparam logic [RADIX_BITS-1:0] RADIX_RESET = itrd_pkg::RADIX_RESET;

    // Expected output beat
    typedef struct packed {
        logic [CHAR_BITS-1:0] digit_char;
        logic                 has_digit;
        logic                 last;
    } digit_beat_t;

    // Directed row: optional radix write, one value, optional typed result
    typedef struct {
        bit                    set_radix;
        logic [RADIX_BITS-1:0] radix;
        logic [TDATA_BITS-1:0] data;
        bit                    typed;
        logic [CHAR_BITS-1:0]  digit_char;
        bit                    has_digit;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [TDATA_BITS-1:0] s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_we = 1'b0;
    logic [RADIX_BITS-1:0] cfg_wdata = '0;

    // Predictor state and scoreboard
    logic [RADIX_BITS-1:0] radix_now = RADIX_RESET;
    digit_beat_t           pending_digits[$];
    stim_row_t             dir_rows[$];
    int                    fail_count = 0;
    int                    beats_checked = 0;
    int                    values_sent = 0;
    int                    radix_writes = 0;
    int                    burst_left = 0;

    integer_to_radix_digits_core #(
        .VALUE_BITS (VB)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Split a value into digits of the current radix, most significant first
    function automatic void predict_digits(input logic [TDATA_BITS-1:0] data);
        logic [VB-1:0]         quo;
        logic [RADIX_BITS-1:0] base;
        logic [DIGIT_BITS-1:0] rems [0:VB-1];
        digit_beat_t           beat;
        int                    n;
        int                    k;
        begin
            base = radix_now;
            if (base < 6'd2)
            begin
                base = 6'd2;
            end
            else if (base > 6'd36)
            begin
                base = 6'd36;
            end
            quo = data[VB-1:0];
            n = 0;
            if (quo == '0)
            begin
                beat = '{digit_char: '0, has_digit: 1'b0, last: 1'b1};
                pending_digits.push_back(beat);
            end
            else
            begin
                while (quo != '0)
                begin
                    rems[n] = DIGIT_BITS'(quo % base);
                    quo = quo / base;
                    n++;
                end
                for (k = n - 1; k >= 0; k--)
                begin
                    if (rems[k] <= 6'd9)
                        beat.digit_char = 7'd48 + CHAR_BITS'(rems[k]);          // '0'..'9'
                    else
                        beat.digit_char = 7'd65 + CHAR_BITS'(rems[k]) - 7'd10;  // 'A'..'Z'
                    beat.has_digit = 1'b1;
                    beat.last = (k == 0);
                    pending_digits.push_back(beat);
                end
            end
        end
    endfunction

    // Hold input low until every digit is out and the core is idle again
    task automatic drain();
        begin
            s_tvalid <= 1'b0;
            burst_left = 0;
            do
                @(posedge clk);
            while (pending_digits.size() != 0 || !s_tready);
        end
    endtask

    // Program the radix while the core is idle
    task automatic set_radix(input logic [RADIX_BITS-1:0] r);
        begin
            drain();
            cfg_we    <= 1'b1;
            cfg_wdata <= r;
            @(posedge clk);
            cfg_we    <= 1'b0;
            radix_now = r;
            radix_writes++;
        end
    endtask

    // Offer one value beat; bursts of random length with random gaps between
    task automatic send_value(input logic [TDATA_BITS-1:0] data, input bit typed,
                              input digit_beat_t typed_beat);
        begin
            if (burst_left == 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                burst_left = $urandom_range(1, 8);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= data;
            do
                @(posedge clk);
            while (!s_tready);
            // Beat accepted at this edge
            if (typed)
                pending_digits.push_back(typed_beat);
            else
                predict_digits(data);
            values_sent++;
            burst_left--;
        end
    endtask

    // Random value mix: zero, max, small, one-hot, full width
    function automatic logic [TDATA_BITS-1:0] pick_value();
        logic [TDATA_BITS-1:0] v;
        begin
            case ($urandom_range(0, 9))
                0: v = '0;
                1: v = {1'b0, {VB{1'b1}}};
                2, 3, 4: v = TDATA_BITS'($urandom_range(1, 2000));
                5: v = TDATA_BITS'(1) << $urandom_range(0, VB - 1);
                default: v = {1'b0, VB'($urandom)};
            endcase
            return v;
        end
    endfunction

    // Output stall pattern: mode re-rolled from a free-running cycle counter
    int unsigned stall_cyc = 0;
    int unsigned stall_mode = 0;
    always @(posedge clk)
    begin
        stall_cyc <= stall_cyc + 1;
        if (stall_cyc % 97 == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (stall_cyc % 4 == 0);
            default: m_tready <= (stall_cyc % 11 < 3);
        endcase
    end

    // Output beat checker
    always @(posedge clk)
    begin
        digit_beat_t exp_beat;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_digits.size() == 0)
            begin
                $error("unexpected output beat: char=%0d has_digit=%0b last=%0b",
                       m_tdata[6:0], m_tuser, m_tlast);
                fail_count++;
            end
            else
            begin
                exp_beat = pending_digits.pop_front();
                beats_checked++;
                if (m_tdata[6:0] !== exp_beat.digit_char)
                begin
                    $error("digit_char: expected %0d, actual %0d",
                           exp_beat.digit_char, m_tdata[6:0]);
                    fail_count++;
                end
                if (m_tuser !== exp_beat.has_digit)
                begin
                    $error("has_digit: expected %0b, actual %0b", exp_beat.has_digit, m_tuser);
                    fail_count++;
                end
                if (m_tlast !== exp_beat.last)
                begin
                    $error("last: expected %0b, actual %0b", exp_beat.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    // Main sequence
    initial
    begin
        stim_row_t   row;
        digit_beat_t tb;
        int          i;
        int          p;
        int          tail;

        // Directed rows; typed results are single-digit or zero cases
        dir_rows.push_back('{0, 6'd0,  32'd0,          1, 7'd0,  0});  // zero at reset radix
        dir_rows.push_back('{0, 6'd0,  32'd7,          1, 7'd55, 1});  // '7'
        dir_rows.push_back('{0, 6'd0,  32'h7FFF_FFFF,  0, 7'd0,  0});
        dir_rows.push_back('{0, 6'd0,  32'd1234567890, 0, 7'd0,  0});
        dir_rows.push_back('{1, 6'd2,  32'd1,          1, 7'd49, 1});  // '1'
        dir_rows.push_back('{0, 6'd0,  32'h7FFF_FFFF,  0, 7'd0,  0});  // 31 digits
        dir_rows.push_back('{0, 6'd0,  32'h4000_0000,  0, 7'd0,  0});
        dir_rows.push_back('{0, 6'd0,  32'd0,          1, 7'd0,  0});
        dir_rows.push_back('{1, 6'd36, 32'd35,         1, 7'd90, 1});  // 'Z'
        dir_rows.push_back('{0, 6'd0,  32'd10,         1, 7'd65, 1});  // 'A'
        dir_rows.push_back('{0, 6'd0,  32'h7FFF_FFFF,  0, 7'd0,  0});
        dir_rows.push_back('{0, 6'd0,  32'd36,         0, 7'd0,  0});
        dir_rows.push_back('{1, 6'd0,  32'd1,          1, 7'd49, 1});  // radix 0 clamps to 2
        dir_rows.push_back('{0, 6'd0,  32'd5,          0, 7'd0,  0});
        dir_rows.push_back('{1, 6'd1,  32'd6,          0, 7'd0,  0});  // radix 1 clamps to 2
        dir_rows.push_back('{1, 6'd63, 32'd35,         1, 7'd90, 1});  // 63 clamps to 36
        dir_rows.push_back('{0, 6'd0,  32'h8000_0000,  1, 7'd0,  0});  // padding bit only
        dir_rows.push_back('{0, 6'd0,  32'hFFFF_FFFF,  0, 7'd0,  0});  // top bit dropped
        dir_rows.push_back('{1, 6'd37, 32'd71,         0, 7'd0,  0});
        dir_rows.push_back('{1, 6'd16, 32'hDEAD_BEEF,  0, 7'd0,  0});
        dir_rows.push_back('{0, 6'd0,  32'd255,        0, 7'd0,  0});
        dir_rows.push_back('{1, 6'd10, 32'd9,          1, 7'd57, 1});  // '9'

        // Reset
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part
        for (i = 0; i < dir_rows.size(); i++)
        begin
            row = dir_rows[i];
            if (row.set_radix)
                set_radix(row.radix);
            tb = '{digit_char: row.digit_char, has_digit: row.has_digit, last: 1'b1};
            send_value(row.data, row.typed, tb);
        end

        // Random phases, each with a fresh radix
        tb = '0;
        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0: set_radix(6'd2);
                1: set_radix(6'd36);
                2: set_radix(6'($urandom_range(0, 63)));
                default: set_radix(6'($urandom_range(2, 36)));
            endcase
            for (i = 0; i < PHASE_LEN; i++)
            begin
                // Hold off now and then until the core is fully drained
                if ((p == 3 && i == 16) || $urandom_range(0, 39) == 0)
                    drain();
                send_value(pick_value(), 1'b0, tb);
            end
        end
        s_tvalid <= 1'b0;

        // Wait for the last digits, then a quiet tail
        while (pending_digits.size() != 0)
            @(posedge clk);
        for (tail = 0; tail < TAIL_CYC; tail++)
            @(posedge clk);

        $display("Converted %0d values across %0d radix writes; %0d digit beats checked.",
                 values_sent, radix_writes, beats_checked);
        if (fail_count == 0 && pending_digits.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Run limit
    initial
    begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
